FILE: hdl/adrg_pkg.sv
// ----------------------------------------------------------------------------
// adrg_pkg: shared types and constants for the ducking gain ramp
// Payload structs for the sample channels and fixed-point constants.
// ----------------------------------------------------------------------------
package adrg_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned GainW   = 16;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 8;

  // Q1.15 unity
  localparam logic [GainW-1:0] Unity = 16'h8000;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegDuckLevel = 8'd0;
  localparam logic [CfgIdxW-1:0] RegOnStep    = 8'd1;
  localparam logic [CfgIdxW-1:0] RegOffStep   = 8'd2;
  localparam logic [CfgIdxW-1:0] RegWetMix    = 8'd3;

  localparam logic [CfgW-1:0] DuckLevelRst = 16'd16384;
  localparam logic [CfgW-1:0] OnStepRst    = 16'd32768;
  localparam logic [CfgW-1:0] OffStepRst   = 16'd32768;
  localparam logic [CfgW-1:0] WetMixRst    = 16'd32768;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_in;
    logic                      sidechain_active;
    logic                      channel_first;
    logic                      block_last;
  } adrg_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_out;
    logic [GainW-1:0]          gain_now;
  } adrg_out_t;

endpackage

FILE: hdl/adrg_stream_if.sv
// ----------------------------------------------------------------------------
// adrg_stream_if: valid/ready stream channel
// One transaction moves at a clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface adrg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/audio_duck_ramp_gain_core.sv
// ----------------------------------------------------------------------------
// audio_duck_ramp_gain_core: sidechain ducking gain with ramped gain
// Ramps a Q1.15 gain toward the duck level or unity and mixes each sample.
// ----------------------------------------------------------------------------
// Each sample runs through the gain, mul1, mul2 and done states before the
// next acceptance: gain ramps and clamps the gain, mul1 and mul2 make two
// passes through the single shared 33x17 signed multiplier (sample times
// gain offset, then times wet mix), and done rounds, saturates and loads
// the output register. The input is ready only while the sequencer is idle;
// a result waiting in the output register does not block the next sample
// until that sample is finished. Registers take writes on any cycle with
// cfg_we_i high; indexes past wet_mix are ignored.
module audio_duck_ramp_gain_core
  import adrg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  adrg_stream_if.sink         in_i,
  adrg_stream_if.source       out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StGain = 3'd1;
  localparam logic [2:0] StMul1 = 3'd2;
  localparam logic [2:0] StMul2 = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  localparam int unsigned MulAW = 33;
  localparam int unsigned MulBW = 17;
  localparam int unsigned AccW  = 48;

  logic [2:0] state_q, state_d;

  logic [CfgW-1:0] duck_level_q, on_step_q, off_step_q, wet_mix_q;
  logic [GainW-1:0] committed_q, working_q, gain_q;
  adrg_in_t item_q;
  logic signed [AccW-1:0] prod_q;

  logic      out_valid_q;
  adrg_out_t out_data_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duck_level_q <= DuckLevelRst;
      on_step_q    <= OnStepRst;
      off_step_q   <= OffStepRst;
      wet_mix_q    <= WetMixRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDuckLevel: duck_level_q <= cfg_wdata_i;
        RegOnStep:    on_step_q    <= cfg_wdata_i;
        RegOffStep:   off_step_q   <= cfg_wdata_i;
        RegWetMix:    wet_mix_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // gain ramp and clamp
  logic [GainW-1:0]   floor_g, wet_g, base_g, new_g;
  logic signed [17:0] ramp_g;

  always_comb begin
    floor_g = (duck_level_q > Unity) ? Unity : duck_level_q;
    wet_g   = (wet_mix_q > Unity) ? Unity : wet_mix_q;
    base_g  = item_q.channel_first ? committed_q : working_q;
    if (item_q.sidechain_active && (base_g > floor_g)) begin
      ramp_g = $signed({2'b00, base_g}) - $signed({2'b00, on_step_q});
    end else if (!item_q.sidechain_active && (base_g < Unity)) begin
      ramp_g = $signed({2'b00, base_g}) + $signed({2'b00, off_step_q});
    end else begin
      ramp_g = $signed({2'b00, base_g});
    end
    if (ramp_g < $signed({2'b00, floor_g})) begin
      new_g = floor_g;
    end else if (ramp_g > $signed({2'b00, Unity})) begin
      new_g = Unity;
    end else begin
      new_g = ramp_g[GainW-1:0];
    end
  end

  // shared multiplier: first pass s*(g-1), second pass times wet
  logic signed [MulAW-1:0]       mul_a;
  logic signed [MulBW-1:0]       mul_b;
  logic signed [MulAW+MulBW-1:0] mul_p;

  always_comb begin
    if (state_q == StMul1) begin
      mul_a = MulAW'(item_q.sample_in);
      mul_b = $signed({1'b0, gain_q}) - $signed({1'b0, Unity});
    end else begin
      mul_a = prod_q[MulAW-1:0];
      mul_b = $signed({1'b0, wet_g});
    end
    mul_p = mul_a * mul_b;
  end

  // round to nearest, ties up, then saturate
  logic signed [AccW-1:0] acc;
  logic signed [17:0]     q_wide;
  logic signed [SampleW-1:0] q_sat;

  always_comb begin
    acc    = (AccW'(item_q.sample_in) <<< 30) + prod_q + (AccW'(1) <<< 29);
    q_wide = 18'(acc >>> 30);
    if (q_wide > 18'sd32767) begin
      q_sat = 16'sh7fff;
    end else if (q_wide < -18'sd32768) begin
      q_sat = 16'sh8000;
    end else begin
      q_sat = q_wide[SampleW-1:0];
    end
  end

  logic in_hs, out_load;
  assign in_hs    = in_i.valid && in_i.ready;
  assign out_load = (state_q == StDone) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_hs) state_d = StGain;
      StGain: state_d = StMul1;
      StMul1: state_d = StMul2;
      StMul2: state_d = StDone;
      StDone: if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      committed_q <= Unity;
      working_q   <= Unity;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StGain) begin
        working_q <= new_g;
        if (item_q.block_last) begin
          committed_q <= new_g;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      item_q <= in_i.data;
    end
    if (state_q == StGain) begin
      gain_q <= new_g;
    end
    if (state_q == StMul1 || state_q == StMul2) begin
      prod_q <= mul_p[AccW-1:0];
    end
    if (out_load) begin
      out_data_q.sample_out <= q_sat;
      out_data_q.gain_now   <= gain_q;
    end
  end

  assign in_i.ready  = (state_q == StIdle);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

FILE: verif/audio_duck_ramp_gain_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_duck_ramp_gain_core_tb: self-checking bench for the ducking gain core
// Drives sample transactions through the valid/ready channels with random
// stalls on both sides, and sweeps the four gain registers between phases.
// A scoreboard predicts each ducked sample and its gain, and compares them
// with every output transaction in order.
// ----------------------------------------------------------------------------
module audio_duck_ramp_gain_core_tb;
  import adrg_pkg::*;

  localparam int UnityGain = int'(Unity);
  localparam logic [CfgIdxW-1:0] RegIdxTop = '1;
  localparam int RandPhases = 15;
  localparam int PhaseItems = 70;

  class duck_gain_scoreboard;
    logic [CfgW-1:0] duck_level;
    logic [CfgW-1:0] on_step;
    logic [CfgW-1:0] off_step;
    logic [CfgW-1:0] wet_mix;
    int              committed_gain;
    int              working_gain;
    adrg_out_t       ducked_q[$];
    int              errors;

    function new();
      duck_level     = DuckLevelRst;
      on_step        = OnStepRst;
      off_step       = OffStepRst;
      wet_mix        = WetMixRst;
      committed_gain = UnityGain;
      working_gain   = UnityGain;
      errors         = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
      case (idx)
        RegDuckLevel: duck_level = value;
        RegOnStep:    on_step    = value;
        RegOffStep:   off_step   = value;
        RegWetMix:    wet_mix    = value;
        default: ;
      endcase
    endfunction

    // ramp and clamp the gain, then mix in Q2.30 with round-half-up
    function adrg_out_t duck_sample(adrg_in_t it);
      int        floor_g;
      int        wet;
      int        g;
      longint    s;
      longint    acc;
      longint    q;
      adrg_out_t r;
      floor_g = (int'(duck_level) > UnityGain) ? UnityGain : int'(duck_level);
      wet     = (int'(wet_mix) > UnityGain) ? UnityGain : int'(wet_mix);
      if (it.channel_first) working_gain = committed_gain;
      g = working_gain;
      if (it.sidechain_active && g > floor_g) g -= int'(on_step);
      if (!it.sidechain_active && g < UnityGain) g += int'(off_step);
      if (g < floor_g) g = floor_g;
      if (g > UnityGain) g = UnityGain;
      s   = longint'($signed(it.sample_in));
      acc = (s <<< 30) + s * longint'(g - UnityGain) * longint'(wet);
      q   = (acc + (longint'(1) <<< 29)) >>> 30;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      r.sample_out = q[SampleW-1:0];
      r.gain_now   = g[GainW-1:0];
      working_gain = g;
      if (it.block_last) committed_gain = working_gain;
      return r;
    endfunction

    function void note_input(adrg_in_t it);
      ducked_q.push_back(duck_sample(it));
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(adrg_out_t got);
      adrg_out_t want;
      if (ducked_q.size() == 0) begin
        report($sformatf("unexpected output sample %0d gain %0d",
                         $signed(got.sample_out), got.gain_now));
        return;
      end
      want = ducked_q.pop_front();
      if (got.sample_out !== want.sample_out)
        report($sformatf("sample_out %0d, predicted %0d",
                         $signed(got.sample_out), $signed(want.sample_out)));
      if (got.gain_now !== want.gain_now)
        report($sformatf("gain_now %0d, predicted %0d", got.gain_now, want.gain_now));
    endtask

    task flush_check();
      if (ducked_q.size() != 0)
        report($sformatf("%0d output transactions never arrived", ducked_q.size()));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;

  adrg_stream_if #(.payload_t(adrg_in_t))  sample_in_if ();
  adrg_stream_if #(.payload_t(adrg_out_t)) sample_out_if ();

  duck_gain_scoreboard sb = new();

  int   src_pct;
  int   sink_pct;
  int   side_left;
  logic side_now;
  int   block_left;

  audio_duck_ramp_gain_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (sample_in_if),
    .out_o       (sample_out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && sample_in_if.valid && sample_in_if.ready) sb.note_input(sample_in_if.data);
  end

  always @(posedge clk_i) begin
    if (rst_ni && sample_out_if.valid && sample_out_if.ready)
      sb.check_result(sample_out_if.data);
  end

  // output backpressure in random bursts
  initial begin
    sample_out_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (sink_pct != 0 && $urandom_range(0, 99) < sink_pct) begin
        sample_out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        sample_out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic push_sample(adrg_in_t it);
    if (src_pct != 0 && $urandom_range(0, 99) < src_pct) begin
      sample_in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    sample_in_if.valid <= 1'b1;
    sample_in_if.data  <= it;
    do @(posedge clk_i); while (!sample_in_if.ready);
  endtask

  task automatic send(logic [SampleW-1:0] s, logic act, logic first, logic last);
    adrg_in_t it;
    it.sample_in        = s;
    it.sidechain_active = act;
    it.channel_first    = first;
    it.block_last       = last;
    push_sample(it);
  endtask

  // drop valid and hold until every predicted output has been seen
  task automatic settle();
    sample_in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.ducked_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CfgW-1:0] pick_step();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'd1;
      2:       return Unity;
      3:       return 16'hFFFF;
      4, 5:    return CfgW'($urandom_range(1, 512));
      default: return CfgW'($urandom_range(1, 32768));
    endcase
  endfunction

  function automatic logic [CfgW-1:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return Unity;
      2:       return 16'hFFFF;
      3:       return CfgW'($urandom_range(32769, 65535));
      default: return CfgW'($urandom_range(0, 32768));
    endcase
  endfunction

  // blocks of samples framed by first/last, sidechain in runs, some noise
  function automatic adrg_in_t next_random_sample();
    adrg_in_t it;
    if (side_left == 0) begin
      side_now  = 1'($urandom_range(0, 1));
      side_left = $urandom_range(1, 40);
    end
    side_left--;
    it.sidechain_active = side_now;
    it.channel_first = (block_left == 0) ? ($urandom_range(0, 9) != 0)
                                         : ($urandom_range(0, 29) == 0);
    if (block_left == 0) block_left = $urandom_range(1, 24);
    block_left--;
    it.block_last = (block_left == 0) ? ($urandom_range(0, 9) != 0)
                                      : ($urandom_range(0, 29) == 0);
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       it.sample_in = 16'h8000;
          1:       it.sample_in = 16'h7FFF;
          2:       it.sample_in = 16'h0000;
          default: it.sample_in = 16'hFFFF;
        endcase
      end
      1:       it.sample_in = SampleW'($urandom_range(0, 64)) - SampleW'(32);
      default: it.sample_in = SampleW'($urandom);
    endcase
    return it;
  endfunction

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= '0;
    cfg_wdata_i        <= '0;
    sample_in_if.valid <= 1'b0;
    sample_in_if.data  <= '0;
    src_pct    = 0;
    sink_pct   = 0;
    side_left  = 0;
    side_now   = 1'b0;
    block_left = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: instant steps, floor at one half
    send(16'h7FFF, 1'b0, 1'b1, 1'b0);
    send(16'h8000, 1'b1, 1'b0, 1'b0);
    send(16'h7FFF, 1'b1, 1'b0, 1'b1);
    send(16'h0000, 1'b0, 1'b1, 1'b0);
    send(16'hFFFF, 1'b1, 1'b1, 1'b1);

    // floor and wet above unity, no downward step
    settle();
    set_reg(RegDuckLevel, 16'hFFFF);
    set_reg(RegWetMix, 16'hFFFF);
    set_reg(RegOnStep, 16'h0000);
    send(16'h8000, 1'b1, 1'b0, 1'b0);
    send(16'd12345, 1'b0, 1'b0, 1'b0);

    // both steps zero with the floor at zero
    settle();
    set_reg(RegDuckLevel, 16'h0000);
    set_reg(RegOffStep, 16'h0000);
    send(16'h7FFF, 1'b1, 1'b0, 1'b0);
    send(16'h8000, 1'b0, 1'b0, 1'b0);

    // smallest step, dry mix
    settle();
    set_reg(RegOnStep, 16'd1);
    set_reg(RegWetMix, 16'h0000);
    send(16'h8000, 1'b1, 1'b0, 1'b0);
    send(16'h7FFF, 1'b1, 1'b0, 1'b0);

    // step far past the floor lands on it exactly
    settle();
    set_reg(RegOnStep, 16'hFFFF);
    set_reg(RegWetMix, Unity);
    send(16'h8000, 1'b1, 1'b0, 1'b0);
    send(16'h7FFF, 1'b1, 1'b0, 1'b1);

    // raise the floor: next sample clamps up whatever the sidechain says
    settle();
    set_reg(RegDuckLevel, 16'd20000);
    send(16'h7FFF, 1'b0, 1'b0, 1'b0);
    send(-16'sd12345, 1'b1, 1'b1, 1'b0);

    settle();
    set_reg(RegOffStep, 16'd1000);
    set_reg(RegWetMix, 16'd16384);
    set_reg(RegDuckLevel, 16'd16384);
    send(16'h7FFF, 1'b0, 1'b0, 1'b0);
    send(16'h8000, 1'b0, 1'b0, 1'b0);
    send(16'd1, 1'b0, 1'b0, 1'b0);
    send(16'h4000, 1'b1, 1'b0, 1'b0);

    // writes past the last register must change nothing
    settle();
    set_reg(RegWetMix + 1'b1, 16'h0000);
    set_reg(RegIdxTop, 16'hFFFF);
    send(16'h8000, 1'b1, 1'b1, 1'b1);
    send(16'h7FFF, 1'b1, 1'b0, 1'b0);

    for (int p = 0; p < RandPhases; p++) begin
      settle();
      set_reg(RegDuckLevel, pick_level());
      set_reg(RegOnStep, pick_step());
      set_reg(RegOffStep, pick_step());
      set_reg(RegWetMix, pick_level());
      if ($urandom_range(0, 2) == 0)
        set_reg(CfgIdxW'($urandom_range(int'(RegWetMix) + 1, int'(RegIdxTop))),
                CfgW'($urandom));
      // last phases run at full rate
      if (p >= RandPhases - 2) begin
        src_pct  = 0;
        sink_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       src_pct = 0;
          1:       src_pct = 10;
          default: src_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0:       sink_pct = 0;
          1:       sink_pct = 10;
          default: sink_pct = 40;
        endcase
      end
      for (int n = 0; n < PhaseItems; n++) push_sample(next_random_sample());
    end

    sample_in_if.valid <= 1'b0;
    while (sb.ducked_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    sb.flush_check();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
